// ----- src/mcsf_pkg.sv -----
// Shared types and constants of the mutual coincidence shift finder.
`timescale 1ns / 1ps
package mcsf_pkg;

	localparam int MAX_COLUMNS_DEF = 32;
	localparam int ALPHABET_DEF    = 26;

	localparam int CNT_W    = 17;
	localparam int LETTER_W = 5;
	localparam int COLCNT_W = 6;
	localparam int COLIDX_W = 5;
	localparam int THR_W    = 16;
	localparam int SCORE_W  = 39;
	localparam int KEY_W    = 5;
	localparam int PROD_W   = 2 * CNT_W;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [COLCNT_W-1:0] COLCNT_RESET = 6'd1;
	localparam logic [THR_W-1:0]    THR_RESET    = 16'd3932;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_COLUMN_COUNT  = 2'd0,
		REG_FIRST_COLUMN  = 2'd1,
		REG_SECOND_COLUMN = 2'd2,
		REG_MIN_INDEX     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_MUL,
		ST_EMIT
	} state_t;

	// Control broadcast to every cell of the histogram ring
	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                inc1;
		logic                inc2;
		logic                rotate;
		logic                clear;
	} cell_ctrl_t;

endpackage

// ----- src/mutual_coincidence_shift_finder_core.sv -----
// Top level: letter intake, histogram ring, correlation sweep and result.
//
// channel  | ports                              | handshake
// ---------+------------------------------------+-------------------------------
// item in  | letter, last_letter                | start & !busy
// result   | found, key_shift, best_score       | done, one cycle, no back-pressure
// config   | psel penable pwrite paddr pwdata   | APB, pready tied high
//
// A letter is taken every cycle while busy is low; it bumps histogram cells, the column
// sizes and the phase. After the last letter, busy stays high while the second histogram
// rotates one step a cycle around the ring of cells and the sums pass through the registered
// adder tree and the threshold multiply.
// done pulses in the final busy cycle; histograms, sizes and phase clear at that edge.
// Reset clears all histograms and control state and loads the register defaults.
`timescale 1ns / 1ps
module mutual_coincidence_shift_finder_core #(
	parameter int MAX_COLUMNS   = mcsf_pkg::MAX_COLUMNS_DEF,
	parameter int ALPHABET_SIZE = mcsf_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mcsf_pkg::ADDR_W-1:0]   paddr,
	input  logic [mcsf_pkg::DATA_W-1:0]   pwdata,
	output logic [mcsf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [mcsf_pkg::LETTER_W-1:0] letter,
	input  logic                          last_letter,
	output logic                          done,
	output logic                          found,
	output logic [mcsf_pkg::KEY_W-1:0]    key_shift,
	output logic [mcsf_pkg::SCORE_W-1:0]  best_score
);
	import mcsf_pkg::*;

	localparam int LVL   = $clog2(ALPHABET_SIZE);
	localparam int SH_W  = $clog2(ALPHABET_SIZE);
	localparam int ISS_W = $clog2(ALPHABET_SIZE + 1);
	localparam int SUM_W = PROD_W + LVL;
	localparam int PH_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CW_W  = $clog2(MAX_COLUMNS + 1);
	localparam int XW    = (CW_W > COLCNT_W) ? CW_W : COLCNT_W;
	localparam int TA_W  = THR_W + CNT_W;
	localparam int TW    = THR_W + 2 * CNT_W;

	// Configuration registers
	logic [COLCNT_W-1:0] column_count_q;
	logic [COLIDX_W-1:0] first_column_q;
	logic [COLIDX_W-1:0] second_column_q;
	logic [THR_W-1:0]    min_index_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= COLCNT_RESET;
			first_column_q  <= '0;
			second_column_q <= '0;
			min_index_q     <= THR_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COLUMN_COUNT:  column_count_q  <= pwdata[COLCNT_W-1:0];
				REG_FIRST_COLUMN:  first_column_q  <= pwdata[COLIDX_W-1:0];
				REG_SECOND_COLUMN: second_column_q <= pwdata[COLIDX_W-1:0];
				REG_MIN_INDEX:     min_index_q     <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COLUMN_COUNT:  prdata = DATA_W'(column_count_q);
			REG_FIRST_COLUMN:  prdata = DATA_W'(first_column_q);
			REG_SECOND_COLUMN: prdata = DATA_W'(second_column_q);
			REG_MIN_INDEX:     prdata = DATA_W'(min_index_q);
			default:           prdata = '0;
		endcase
	end

	// Control state
	state_t            state_q, state_d;
	logic [PH_W-1:0]   phase_q;
	logic [CNT_W-1:0]  n1_q, n2_q;
	logic [ISS_W-1:0]  iss_q;
	logic              tag_v_q [0:LVL];
	logic [SH_W-1:0]   tag_sh_q [0:LVL];
	logic              accept, issuing, sweep_end;

	assign accept    = start & ~busy;
	assign issuing   = (state_q == ST_RUN) && (iss_q != ISS_W'(ALPHABET_SIZE));
	assign sweep_end = tag_v_q[LVL] && (tag_sh_q[LVL] == SH_W'(ALPHABET_SIZE - 1));

	// Column dealing
	logic [XW-1:0] count_eff, phase_cur, phase_inc;
	logic          letter_ok, hit1, hit2;

	always_comb begin
		count_eff = XW'(column_count_q);
		if (count_eff == '0) begin
			count_eff = XW'(1);
		end else if (count_eff > XW'(MAX_COLUMNS)) begin
			count_eff = XW'(MAX_COLUMNS);
		end
		phase_cur = (XW'(phase_q) >= count_eff) ? '0 : XW'(phase_q);
		phase_inc = phase_cur + 1'b1;
	end

	assign letter_ok = int'(letter) < ALPHABET_SIZE;
	assign hit1      = accept && letter_ok && (phase_cur == XW'(first_column_q));
	assign hit2      = accept && letter_ok && (phase_cur == XW'(second_column_q));

	// Hold phase and column sizes; drop them when the result goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			n1_q    <= '0;
			n2_q    <= '0;
		end else if (state_q == ST_EMIT) begin
			phase_q <= '0;
			n1_q    <= '0;
			n2_q    <= '0;
		end else if (accept) begin
			phase_q <= (phase_inc >= count_eff) ? '0 : PH_W'(phase_inc);
			if (hit1 && (n1_q != '1)) begin
				n1_q <= n1_q + 1'b1;
			end
			if (hit2 && (n2_q != '1)) begin
				n2_q <= n2_q + 1'b1;
			end
		end
	end

	// Ring of cells
	cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]  h2_ring [ALPHABET_SIZE];
	logic [PROD_W-1:0] prod [ALPHABET_SIZE];
	logic [SUM_W-1:0]  sum;

	always_comb begin
		ctrl.letter = letter;
		ctrl.inc1   = hit1;
		ctrl.inc2   = hit2;
		ctrl.rotate = issuing;
		ctrl.clear  = (state_q == ST_EMIT);
	end

	for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
		mcsf_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.h2_in  (h2_ring[(i + ALPHABET_SIZE - 1) % ALPHABET_SIZE]),
			.h2_out (h2_ring[i]),
			.prod_s1(prod[i])
		);
	end

	mcsf_sum_tree #(
		.N (ALPHABET_SIZE),
		.IW(PROD_W)
	) u_tree (
		.clk (clk),
		.leaf(prod),
		.sum (sum)
	);

	// Advance the shift counter and the tags that follow the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			for (int k = 0; k <= LVL; k++) begin
				tag_v_q[k]  <= 1'b0;
				tag_sh_q[k] <= '0;
			end
		end else begin
			if (state_q == ST_IDLE) begin
				iss_q <= '0;
			end else if (issuing) begin
				iss_q <= iss_q + 1'b1;
			end
			tag_v_q[0]  <= issuing;
			tag_sh_q[0] <= SH_W'(iss_q);
			for (int k = 1; k <= LVL; k++) begin
				tag_v_q[k]  <= tag_v_q[k-1];
				tag_sh_q[k] <= tag_sh_q[k-1];
			end
		end
	end

	// Keep the best sum; the first shift always loads, ties keep the earlier
	logic [SUM_W-1:0] best_q;
	logic [SH_W-1:0]  bshift_q;
	logic [TA_W-1:0]  thra_q;
	logic [TW-1:0]    thr_q;

	always_ff @(posedge clk) begin
		if (tag_v_q[LVL] && ((tag_sh_q[LVL] == '0) || (sum > best_q))) begin
			best_q   <= sum;
			bshift_q <= tag_sh_q[LVL];
		end
		thra_q <= TA_W'(min_index_q) * TA_W'(n1_q);
		if (state_q == ST_MUL) begin
			thr_q <= TW'(thra_q) * TW'(n2_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && last_letter) state_d = ST_RUN;
			ST_RUN:  if (sweep_end) state_d = ST_MUL;
			ST_MUL:  state_d = ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_EMIT);
		found      = (n1_q != '0) && (n2_q != '0) &&
		             ((64'(best_q) << THR_W) >= 64'(thr_q));
		key_shift  = found ? KEY_W'(ALPHABET_SIZE - int'(bshift_q)) : '0;
		best_score = SCORE_W'(best_q);
	end

`ifndef ASSERT_OFF
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_letter) |=> busy)
		else $error("last letter did not start the sweep");
	a_plain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_letter) |=> !busy)
		else $error("plain letter left the block busy");
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block still busy after result");
	a_nf_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (key_shift == '0))
		else $error("key shift set without a find");
	a_done_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_MUL))
		else $error("result without threshold product");
`endif

endmodule

// ----- src/mcsf_cell.sv -----
// One letter slot of the ring: both histogram counts and their product.
`timescale 1ns / 1ps
module mcsf_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcsf_pkg::cell_ctrl_t        ctrl,
	input  logic [mcsf_pkg::CNT_W-1:0]  h2_in,
	output logic [mcsf_pkg::CNT_W-1:0]  h2_out,
	output logic [mcsf_pkg::PROD_W-1:0] prod_s1
);
	import mcsf_pkg::*;

	logic [CNT_W-1:0] h1_q;
	logic [CNT_W-1:0] h2_q;
	logic             hit;

	assign hit    = (int'(ctrl.letter) == IDX);
	assign h2_out = h2_q;

	// Count letters, rotate the second histogram, drop both when the result goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctrl.clear) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctrl.rotate) begin
			h2_q <= h2_in;
		end else begin
			if (hit && ctrl.inc1 && (h1_q != '1)) begin
				h1_q <= h1_q + 1'b1;
			end
			if (hit && ctrl.inc2 && (h2_q != '1)) begin
				h2_q <= h2_q + 1'b1;
			end
		end
	end

	// Register this slot's product term
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(h1_q) * PROD_W'(h2_q);
	end

endmodule

// ----- src/mcsf_sum_tree.sv -----
// Registered adder tree summing the product terms of all cells.
`timescale 1ns / 1ps
module mcsf_sum_tree #(
	parameter int N  = mcsf_pkg::ALPHABET_DEF,
	parameter int IW = mcsf_pkg::PROD_W
) (
	input  logic                     clk,
	input  logic [IW-1:0]            leaf [N],
	output logic [IW+$clog2(N)-1:0]  sum
);
	localparam int LVL = $clog2(N);
	localparam int P   = 1 << LVL;
	localparam int OW  = IW + LVL;

	logic [OW-1:0] leaf_x [P];
	logic [OW-1:0] node_q [1:LVL][P];

	// Pad the leaves to a power of two
	always_comb begin
		for (int j = 0; j < P; j++) begin
			leaf_x[j] = (j < N) ? OW'(leaf[j]) : '0;
		end
	end

	// Add pairs, one level per cycle
	always_ff @(posedge clk) begin
		for (int j = 0; j < (P >> 1); j++) begin
			node_q[1][j] <= leaf_x[2*j] + leaf_x[2*j+1];
		end
		for (int l = 2; l <= LVL; l++) begin
			for (int j = 0; j < (P >> l); j++) begin
				node_q[l][j] <= node_q[l-1][2*j] + node_q[l-1][2*j+1];
			end
		end
	end

	assign sum = node_q[LVL][0];

endmodule
